// ===== design/ird_pkg.sv =====
// Package for the input-restricted deque: operation and status codes,
// controller states and the command struct sent to every storage cell.
// No dependencies.
package ird_pkg;

  localparam int DATA_W = 32;
  localparam int OP_W = 2;
  localparam int STATUS_W = 2;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT_FRONT = 2'd0,
    OP_REMOVE_FRONT = 2'd1,
    OP_REMOVE_BACK  = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    S_READY = 1'b0,
    S_TAIL  = 1'b1
  } state_e;

  // One command for the whole row of cells.
  typedef struct packed {
    logic shift_in;   // insert at the front: every cell takes its left neighbour
    logic shift_out;  // remove at the front: every cell takes its right neighbour
    logic drop_back;  // remove at the back: the last occupied cell goes vacant
  } cell_cmd_t;

endpackage

// ===== design/ird_cell.sv =====
// One storage cell of the deque row: an entry and its occupied flag.
// Depends on ird_pkg for the data type and the row command struct.
module ird_cell import ird_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_cmd_t cmd_i,
  input  data_t     left_data_i,
  input  logic      left_valid_i,
  input  data_t     right_data_i,
  input  logic      right_valid_i,
  output data_t     data_o,
  output logic      valid_o
);

  data_t data_q, data_d;
  logic  valid_q, valid_d;

  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    if (cmd_i.shift_in) begin
      data_d  = left_data_i;
      valid_d = left_valid_i;
    end else if (cmd_i.shift_out) begin
      data_d  = right_data_i;
      valid_d = right_valid_i;
    end else if (cmd_i.drop_back) begin
      // Occupancy is a thermometer, so the vacant end moves in by one.
      valid_d = right_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign valid_o = valid_q;

endmodule

// ===== design/ird_tail_tree.sv =====
// Registered OR tree that picks out the entry of the last occupied cell.
// Depends on ird_pkg for the data type.
module ird_tail_tree import ird_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  logic             clk_i,
  input  data_t            data_i [DEPTH],
  input  logic [DEPTH-1:0] valid_i,
  output data_t            tail_o
);

  localparam int LEVELS = $clog2(DEPTH);
  localparam int LEAVES = 1 << LEVELS;

  // Heap order: node n combines nodes 2n and 2n+1, leaves sit at LEAVES and up.
  data_t nodes_q [1:2*LEAVES-1];

  for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
    if (i < DEPTH - 1) begin : g_inner
      always_ff @(posedge clk_i) begin
        nodes_q[LEAVES+i] <= (valid_i[i] && !valid_i[i+1]) ? data_i[i] : '0;
      end
    end else if (i == DEPTH - 1) begin : g_last
      always_ff @(posedge clk_i) begin
        nodes_q[LEAVES+i] <= valid_i[i] ? data_i[i] : '0;
      end
    end else begin : g_pad
      always_ff @(posedge clk_i) begin
        nodes_q[LEAVES+i] <= '0;
      end
    end
  end

  for (genvar n = 1; n < LEAVES; n++) begin : g_node
    always_ff @(posedge clk_i) begin
      nodes_q[n] <= nodes_q[2*n] | nodes_q[2*n+1];
    end
  end

  assign tail_o = nodes_q[1];

endmodule

// ===== design/input_restricted_deque.sv =====
// Top level of the input-restricted deque: controller, row of storage cells
// and tail tree. Depends on ird_pkg, ird_cell and ird_tail_tree.
//
//   Channel  Direction  tdata            tuser
//   s_axis   in         value            op
//   m_axis   out        data             status, full_res, empty_res
//
// An insert, a removal at the front, any removal from an empty deque and the
// unused code are answered straight from the ready state; a removal at the back
// from a non-empty deque waits in the tail state until the registered tail tree
// has settled on the current contents and the back entry can be read.
// Reset clears the occupied flags of all cells at once; no clearing pass.
// Results wait in an output register; a new transaction is taken only in the ready state,
// in the cycle that register is emptied, so a stall on m_axis stalls s_axis by one item.
module input_restricted_deque import ird_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [DATA_W-1:0]   s_axis_tdata,   // [31:0] value
  input  logic [OP_W-1:0]     s_axis_tuser,   // [1:0] op
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [DATA_W-1:0]   m_axis_tdata,   // [31:0] data
  output logic [STATUS_W+1:0] m_axis_tuser    // [1:0] status, [2] full_res, [3] empty_res
);

  // The tail state counter walks the tree from its leaf stage up to the root.
  localparam int LEVELS = $clog2(DEPTH);
  localparam int CNT_W = $clog2(LEVELS + 1);

  // Controller state.
  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  // Output register.
  logic    out_valid_q, out_valid_d;
  data_t   out_data_q, out_data_d;
  status_e out_status_q, out_status_d;
  logic    out_full_q, out_full_d;
  logic    out_empty_q, out_empty_d;

  // Row of cells.
  cell_cmd_t        cmd;
  data_t            cell_data [DEPTH];
  logic [DEPTH-1:0] cell_valid;
  data_t            tail;

  logic in_fire;
  logic out_free;
  logic produce;
  op_e  op;
  logic full_now;
  logic empty_now;

  assign op        = op_e'(s_axis_tuser);
  assign full_now  = cell_valid[DEPTH-1];
  assign empty_now = !cell_valid[0];
  assign out_free  = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_READY) && out_free;
  assign in_fire   = s_axis_tvalid && s_axis_tready;

  // The front of the deque is always cell 0; occupied cells form a run from
  // there, so the back is the last occupied cell.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    data_t left_data, right_data;
    logic  left_valid, right_valid;

    if (i == 0) begin : g_first
      assign left_data  = data_t'(s_axis_tdata);
      assign left_valid = 1'b1;
    end else begin : g_mid_left
      assign left_data  = cell_data[i-1];
      assign left_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_data  = '0;
      assign right_valid = 1'b0;
    end else begin : g_mid_right
      assign right_data  = cell_data[i+1];
      assign right_valid = cell_valid[i+1];
    end

    ird_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .left_data_i   (left_data),
      .left_valid_i  (left_valid),
      .right_data_i  (right_data),
      .right_valid_i (right_valid),
      .data_o        (cell_data[i]),
      .valid_o       (cell_valid[i])
    );
  end

  ird_tail_tree #(
    .DEPTH (DEPTH)
  ) u_tail_tree (
    .clk_i   (clk_i),
    .data_i  (cell_data),
    .valid_i (cell_valid),
    .tail_o  (tail)
  );

  // Next state: a removal at the back from a non-empty deque parks the
  // controller until the tail tree has settled on the present contents.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_READY: begin
        if (in_fire && op == OP_REMOVE_BACK && !empty_now) begin
          state_d = S_TAIL;
          cnt_d   = CNT_W'(LEVELS);
        end
      end
      S_TAIL: begin
        if (cnt_q == '0) begin
          state_d = S_READY;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      default: begin
        state_d = S_READY;
      end
    endcase
  end

  // Outputs: row commands and the result of each transaction.
  always_comb begin
    cmd          = '0;
    produce      = 1'b0;
    out_data_d   = '0;
    out_status_d = ST_OK;
    out_full_d   = full_now;
    out_empty_d  = empty_now;
    case (state_q)
      S_READY: begin
        if (in_fire) begin
          case (op)
            OP_INSERT_FRONT: begin
              produce = 1'b1;
              if (full_now) begin
                out_status_d = ST_FULL;
              end else begin
                cmd.shift_in = 1'b1;
                out_full_d   = (DEPTH == 1) || cell_valid[DEPTH-2];
                out_empty_d  = 1'b0;
              end
            end
            OP_REMOVE_FRONT: begin
              produce = 1'b1;
              if (empty_now) begin
                out_status_d = ST_EMPTY;
              end else begin
                cmd.shift_out = 1'b1;
                out_data_d    = cell_data[0];
                out_full_d    = 1'b0;
                out_empty_d   = !cell_valid[1];
              end
            end
            OP_REMOVE_BACK: begin
              // A removal from a non-empty deque completes in the tail state.
              if (empty_now) begin
                produce      = 1'b1;
                out_status_d = ST_EMPTY;
              end
            end
            default: begin
              // The unused code changes nothing and reports the flags as they are.
              produce = 1'b1;
            end
          endcase
        end
      end
      S_TAIL: begin
        if (cnt_q == '0) begin
          produce        = 1'b1;
          cmd.drop_back  = 1'b1;
          out_data_d     = tail;
          out_full_d     = 1'b0;
          out_empty_d    = !cell_valid[1];
        end
      end
      default: begin
        produce = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (produce) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_READY;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (produce) begin
      out_data_q   <= out_data_d;
      out_status_q <= out_status_d;
      out_full_q   <= out_full_d;
      out_empty_q  <= out_empty_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = {out_empty_q, out_full_q, out_status_q};

  // Occupied cells always form one run starting at the front cell.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cell_valid >> 1) & ~cell_valid) == '0)
    else $error("occupied cells do not form a run from the front");

  // The row must not move while the tail tree is settling.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TAIL && $past(state_q == S_TAIL)) |-> $stable(cell_valid))
    else $error("cells changed during a removal at the back");

  // A refused insert reports a full deque.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == ST_FULL) |-> (out_full_q && !out_empty_q))
    else $error("insert refused without a full deque");

  // A refused removal reports an empty deque and zero data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == ST_EMPTY) |-> (out_empty_q && out_data_q == '0))
    else $error("removal refused without an empty deque");

endmodule

// ===== test/tb_input_restricted_deque.sv =====
// Self-checking testbench for the input-restricted deque: a directed opening followed by
// random traffic, both stream sides idling at random, every result checked against a
// cycle-free predictor. Depends on ird_pkg and input_restricted_deque.
module tb_input_restricted_deque;
  import ird_pkg::*;

  localparam int DEPTH          = 8;
  localparam int PTR_W          = $clog2(DEPTH);
  localparam int RANDOM_ITEMS   = 1800;
  // A removal at the back settles through the tail tree; the drain below is sized from its
  // depth, so a short tail after the last result is ample.
  localparam int DRAIN_CYCLES   = 4 * (2 + PTR_W);
  // The longest legal silence is a long sender gap plus a long receiver stall
  // plus the back-removal latency; the limit sits well above that.
  localparam int WATCHDOG_LIMIT = 1000;

  // The op field is two bits wide but only three codes are defined; the fourth must
  // be ignored by the block, so it is exercised too.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0] op;
    data_t           value;
  } request_t;

  typedef struct packed {
    data_t   data;
    status_e status;
    logic    full;
    logic    empty;
  } deque_res_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [DATA_W-1:0]   s_axis_tdata  = '0;   // [31:0] value
  logic [OP_W-1:0]     s_axis_tuser  = '0;   // [1:0] op
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [DATA_W-1:0]   m_axis_tdata;         // [31:0] data
  logic [STATUS_W+1:0] m_axis_tuser;         // [1:0] status, [2] full_res, [3] empty_res

  input_restricted_deque #(.DEPTH(DEPTH)) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Requests still to be offered on the input side, and the results predicted for
  // requests the block has already taken, oldest first.
  request_t   request_q[$];
  deque_res_t predicted_result_q[$];

  int errors = 0;

  // Outcome tallies for the closing summary.
  int n_inserted      = 0;
  int n_refused_full  = 0;
  int n_refused_empty = 0;
  int n_removed_front = 0;
  int n_removed_back  = 0;
  int n_emptied       = 0;
  int n_ignored       = 0;
  int n_full_reached  = 0;

  // ---------------------------------------------------------------------------
  // Predictor: a circular store of its own. Entries go in at the front, which moves
  // down with wrap-around; they leave at either end, and the pointers go back to zero
  // whenever the last entry leaves.
  // ---------------------------------------------------------------------------
  data_t            ring_store[DEPTH];
  logic [PTR_W-1:0] ring_front  = '0;
  logic [PTR_W-1:0] ring_back   = '0;
  logic             ring_vacant = 1'b1;

  function automatic logic [PTR_W-1:0] ring_next(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ring_prev(logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(DEPTH - 1) : p - PTR_W'(1);
  endfunction

  function automatic logic ring_full();
    return !ring_vacant && (ring_front == ring_next(ring_back));
  endfunction

  function automatic deque_res_t deque_apply(request_t req);
    deque_res_t res;
    res.data   = '0;
    res.status = ST_OK;
    case (req.op)
      OP_INSERT_FRONT: begin
        if (ring_full()) begin
          res.status = ST_FULL;
          n_refused_full++;
        end else begin
          if (ring_vacant) begin
            ring_front  = '0;
            ring_back   = '0;
            ring_vacant = 1'b0;
          end else begin
            ring_front = ring_prev(ring_front);
          end
          ring_store[ring_front] = req.value;
          n_inserted++;
        end
      end
      OP_REMOVE_FRONT, OP_REMOVE_BACK: begin
        if (ring_vacant) begin
          res.status = ST_EMPTY;
          n_refused_empty++;
        end else if (ring_front == ring_back) begin
          // The only entry leaves whichever end is asked for.
          res.data    = ring_store[ring_front];
          ring_front  = '0;
          ring_back   = '0;
          ring_vacant = 1'b1;
          n_emptied++;
        end else if (req.op == OP_REMOVE_FRONT) begin
          res.data   = ring_store[ring_front];
          ring_front = ring_next(ring_front);
          n_removed_front++;
        end else begin
          res.data  = ring_store[ring_back];
          ring_back = ring_prev(ring_back);
          n_removed_back++;
        end
      end
      default: begin
        n_ignored++;
      end
    endcase
    res.full  = ring_full();
    res.empty = ring_vacant;
    if (res.full) n_full_reached++;
    return res;
  endfunction

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Values lean on the extremes of the signed range, zero, all ones and alternating bit
  // patterns now and then; otherwise every bit is drawn at random.
  function automatic data_t pick_value();
    case ($urandom_range(0, 11))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      4:       return 32'hAAAA_AAAA;
      5:       return 32'h5555_5555;
      default: return data_t'($urandom);
    endcase
  endfunction

  task automatic queue_request(logic [OP_W-1:0] op, data_t value);
    request_t req;
    req.op    = op;
    req.value = value;
    request_q.push_back(req);
  endtask

  // ---------------------------------------------------------------------------
  // Input side driver. Each transaction that the block takes is run through the
  // predictor at the edge where it is accepted; then the next request is either
  // presented or held back for a random gap. Long stretches with no gaps at all
  // come and go at random.
  // ---------------------------------------------------------------------------
  request_t offered_req;
  int       send_gap    = 0;
  logic     send_steady = 1'b0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predicted_result_q.push_back(deque_apply(offered_req));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (request_q.size() > 0) begin
          offered_req    = request_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= offered_req.value;
          s_axis_tuser  <= offered_req.op;
          send_gap       = send_steady ? 0 : idle_gap();
          if ($urandom_range(0, 99) == 0) send_steady = !send_steady;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output side monitor. Every accepted transaction is compared field by field
  // with the oldest prediction. The ready line stalls at random in the same
  // manner as the sender idles.
  // ---------------------------------------------------------------------------
  int   recv_stall  = 0;
  logic recv_steady = 1'b0;

  always @(posedge clk_i) begin
    deque_res_t want;
    deque_res_t got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.data   = m_axis_tdata;
        got.status = status_e'(m_axis_tuser[1:0]);
        got.full   = m_axis_tuser[2];
        got.empty  = m_axis_tuser[3];
        if (predicted_result_q.size() == 0) begin
          $error("result arrived with none predicted: data=%h tuser=%b",
                 m_axis_tdata, m_axis_tuser);
          errors++;
        end else begin
          want = predicted_result_q.pop_front();
          if (got.data !== want.data) begin
            $error("data: expected %h, got %h", want.data, got.data);
            errors++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
          end
          if (got.full !== want.full) begin
            $error("full_res: expected %b, got %b", want.full, got.full);
            errors++;
          end
          if (got.empty !== want.empty) begin
            $error("empty_res: expected %b, got %b", want.empty, got.empty);
            errors++;
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        m_axis_tready <= 1'b0;
      end else if (!recv_steady && $urandom_range(0, 99) < 15) begin
        recv_stall     = idle_gap();
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
      if ($urandom_range(0, 199) == 0) recv_steady = !recv_steady;
    end
  end

  // Watchdog: a hung handshake on either side ends the run as a failure.
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, predicted_result_q.size());
        $display("tb_input_restricted_deque: done, errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    int   phase_left;
    int   insert_pct;
    int   i;
    logic [OP_W-1:0] op;

    // Directed opening. Removals and an unused code on an empty queue, one entry
    // in and out again, then a fill to capacity with the extreme values, a
    // refused insert and an ignored code on the full queue, and a drain from both
    // ends, with one insert on the way, down to empty once more.
    queue_request(OP_REMOVE_FRONT, 32'h1234_5678);
    queue_request(OP_REMOVE_BACK,  32'hFFFF_FFFF);
    queue_request(OP_UNUSED,       32'hDEAD_BEEF);
    queue_request(OP_INSERT_FRONT, 32'h7FFF_FFFF);
    queue_request(OP_REMOVE_BACK,  32'h0000_0000);
    queue_request(OP_INSERT_FRONT, 32'h8000_0000);
    queue_request(OP_INSERT_FRONT, 32'h7FFF_FFFF);
    queue_request(OP_INSERT_FRONT, 32'h0000_0000);
    queue_request(OP_INSERT_FRONT, 32'hFFFF_FFFF);
    queue_request(OP_INSERT_FRONT, 32'hAAAA_AAAA);
    queue_request(OP_INSERT_FRONT, 32'h5555_5555);
    queue_request(OP_INSERT_FRONT, 32'h0000_0001);
    queue_request(OP_INSERT_FRONT, 32'h1234_5678);
    queue_request(OP_INSERT_FRONT, 32'hCAFE_F00D);
    queue_request(OP_UNUSED,       32'h0BAD_0BAD);
    queue_request(OP_REMOVE_FRONT, 32'h0000_0000);
    queue_request(OP_REMOVE_BACK,  32'h0000_0000);
    queue_request(OP_INSERT_FRONT, 32'h8000_0001);
    for (i = 0; i < DEPTH - 1; i++) begin
      queue_request((i % 2 == 0) ? OP_REMOVE_BACK : OP_REMOVE_FRONT, data_t'($urandom));
    end

    // Random part in phases: filling, draining or balanced, so the queue keeps
    // sweeping between empty and full and the pointers wrap many times over.
    // A small share of requests carries the unused code.
    phase_left = 0;
    insert_pct = 50;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(10, 60);
        case ($urandom_range(0, 2))
          0:       insert_pct = 85;
          1:       insert_pct = 15;
          default: insert_pct = 50;
        endcase
      end
      phase_left--;
      if ($urandom_range(0, 99) < 2) begin
        op = OP_UNUSED;
      end else if ($urandom_range(0, 99) < insert_pct) begin
        op = OP_INSERT_FRONT;
      end else begin
        op = $urandom_range(0, 1) ? OP_REMOVE_FRONT : OP_REMOVE_BACK;
      end
      queue_request(op, pick_value());
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sampled on the falling edge, clear of the updates made at the rising one.
    while (request_q.size() != 0 || s_axis_tvalid || predicted_result_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered: %0d inserts, %0d front and %0d back removals, %0d last-entry removals",
             n_inserted, n_removed_front, n_removed_back, n_emptied);
    $display("covered: %0d refused as full, %0d refused as empty, %0d ignored, %0d full",
             n_refused_full, n_refused_empty, n_ignored, n_full_reached);
    if (errors == 0) begin
      $display("tb_input_restricted_deque: done, clean");
    end else begin
      $display("tb_input_restricted_deque: done, errors");
    end
    $finish;
  end

endmodule
